// ----- hw/rtl/assert_macros.svh -----
// Assertion helpers used by the checker file fcc_checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expr holds at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed");

// ante at one edge implies cons at the next edge
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

// ante implies cons at the same edge
`define ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

`endif

// ----- hw/rtl/fcc_pkg.sv -----
package fcc_pkg;

   localparam int TABLE_SIZE         = 512;
   localparam int ADDR_W             = $clog2(TABLE_SIZE);
   localparam int FIRST_DATA_CLUSTER = 2;
   localparam int DATA_CLUSTERS      = TABLE_SIZE - FIRST_DATA_CLUSTER;
   localparam int FIELD_W            = 9;
   // table entry: top bit marks end of chain, low bits hold the link; all zero is free
   localparam int ENTRY_W            = ADDR_W + 1;
   localparam int CNT_W              = ADDR_W + 1;

   localparam logic [ENTRY_W-1:0] ENT_EMPTY = '0;
   localparam logic [ENTRY_W-1:0] ENT_END   = {1'b1, {ADDR_W{1'b0}}};

   typedef enum logic [1:0] {
      CMD_ALLOC = 2'd0,
      CMD_FREE  = 2'd1,
      CMD_WALK  = 2'd2,
      CMD_NONE  = 2'd3
   } cmd_type;

   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_FULL = 2'd1;
   localparam logic [1:0] ST_BAD  = 2'd2;
   localparam logic [1:0] ST_LONG = 2'd3;

   typedef struct packed {
      logic [1:0]         command;
      logic [FIELD_W-1:0] alloc_count;
      logic [FIELD_W-1:0] start_cluster;
   } req_type;

   typedef struct packed {
      logic [FIELD_W-1:0] head_cluster;
      logic [FIELD_W-1:0] chain_length;
      logic [1:0]         status;
   } rsp_type;

   typedef struct packed {
      cmd_type            cmd;
      logic [FIELD_W-1:0] want;
      logic [FIELD_W-1:0] start;
      logic               start_bad;
   } op_type;

endpackage

// ----- hw/rtl/fat_cluster_chain_engine_core.sv -----
// Cluster chain engine: keeps a 512-entry allocation table and runs allocate, free and
// walk requests, one word in and one result word out per request. After reset the
// table is swept once, one entry a cycle, before the first request runs; requests may
// be queued meanwhile. Allocate streams through the table at most twice, one entry a
// cycle; walk issues a registered table read per chain link, and free walks the chain
// twice, once to check it and once to clear it. The single table memory port pair
// sets this pace. Two requests and two results are buffered on either side.
module fat_cluster_chain_engine_core
   import fcc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_push,
   output logic    req_full,
   input  req_type req_data,
   output logic    rsp_empty,
   input  logic    rsp_pop,
   output rsp_type rsp_data
);

   logic    op_valid, op_pop;
   op_type  op_data;
   logic    res_push, res_full;
   rsp_type res_data;

   fcc_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_data (req_data),
      .req_full (req_full),
      .op_valid (op_valid),
      .op_data  (op_data),
      .op_pop   (op_pop)
   );

   fcc_back u_back (
      .clock    (clock),
      .reset    (reset),
      .op_valid (op_valid),
      .op_data  (op_data),
      .op_pop   (op_pop),
      .res_push (res_push),
      .res_data (res_data),
      .res_full (res_full)
   );

   fcc_rsp_queue u_rsp (
      .clock     (clock),
      .reset     (reset),
      .push      (res_push),
      .push_data (res_data),
      .full      (res_full),
      .rsp_pop   (rsp_pop),
      .rsp_empty (rsp_empty),
      .rsp_data  (rsp_data)
   );

endmodule

// ----- hw/rtl/fcc_ram.sv -----
module fcc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/fcc_front.sv -----
module fcc_front
   import fcc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_push,
   input  req_type req_data,
   output logic    req_full,
   output logic    op_valid,
   output op_type  op_data,
   input  logic    op_pop
);

   op_type     slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   op_type     op_new;
   logic       push_ok, pop_ok;

   always_comb begin
      op_new.cmd       = cmd_type'(req_data.command);
      op_new.want      = (req_data.alloc_count == '0) ? FIELD_W'(1)
                                                       : req_data.alloc_count;
      op_new.start     = req_data.start_cluster;
      op_new.start_bad = (int'(req_data.start_cluster) < FIRST_DATA_CLUSTER) ||
                         (int'(req_data.start_cluster) >= TABLE_SIZE);
   end

   assign req_full = (cnt_ff == 2'd2);
   assign op_valid = (cnt_ff != 2'd0);
   assign op_data  = slot_ff[rd_ptr_ff];
   assign push_ok  = req_push && !req_full;
   assign pop_ok   = op_pop && op_valid;

   always_comb begin
      wr_ptr_in = push_ok ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop_ok ? !rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + 2'(push_ok) - 2'(pop_ok);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
      if (push_ok) begin
         slot_ff[wr_ptr_ff] <= op_new;
      end
   end

endmodule

// ----- hw/rtl/fcc_rsp_queue.sv -----
module fcc_rsp_queue
   import fcc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  rsp_type push_data,
   output logic    full,
   input  logic    rsp_pop,
   output logic    rsp_empty,
   output rsp_type rsp_data
);

   rsp_type    slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push_ok, pop_ok;

   assign full      = (cnt_ff == 2'd2);
   assign rsp_empty = (cnt_ff == 2'd0);
   assign rsp_data  = slot_ff[rd_ptr_ff];
   assign push_ok   = push && !full;
   assign pop_ok    = rsp_pop && !rsp_empty;

   always_comb begin
      wr_ptr_in = push_ok ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop_ok ? !rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + 2'(push_ok) - 2'(pop_ok);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
      if (push_ok) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- hw/rtl/fcc_back.sv -----
module fcc_back
   import fcc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    op_valid,
   input  op_type  op_data,
   output logic    op_pop,
   output logic    res_push,
   output rsp_type res_data,
   input  logic    res_full
);

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_A_CNT, S_A_LINK, S_A_END,
      S_W_RD, S_W_CHK, S_F_RD, S_F_CLR, S_DONE
   } state_type;

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   ptr_ff, ptr_in;
   logic               chk_vld_ff, chk_vld_in;
   logic [ADDR_W-1:0]  chk_ptr_ff, chk_ptr_in;
   logic [FIELD_W-1:0] found_ff, found_in;
   logic [ADDR_W-1:0]  prev_ff, prev_in;
   logic [ADDR_W-1:0]  head_ff, head_in;
   logic [ADDR_W-1:0]  cur_ff, cur_in;
   logic [CNT_W-1:0]   n_ff, n_in;
   op_type             op_ff, op_in;
   rsp_type            res_ff, res_in;

   logic               wr_en;
   logic [ADDR_W-1:0]  wr_addr;
   logic [ENTRY_W-1:0] wr_data;
   logic [ADDR_W-1:0]  rd_addr;
   logic [ENTRY_W-1:0] rd_data;

   logic               issue, hit, last_chk;
   logic [FIELD_W-1:0] found_nx;
   logic [CNT_W-1:0]   n_nx;
   logic [ADDR_W-1:0]  link;

   fcc_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_SIZE)) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign issue    = (ptr_ff < CNT_W'(TABLE_SIZE));
   assign hit      = chk_vld_ff && (rd_data == ENT_EMPTY);
   assign last_chk = chk_vld_ff && (chk_ptr_ff == ADDR_W'(TABLE_SIZE - 1));
   assign found_nx = found_ff + FIELD_W'(1);
   assign n_nx     = n_ff + CNT_W'(1);
   assign link     = rd_data[ADDR_W-1:0];
   assign res_push = (state_ff == S_DONE);
   assign res_data = res_ff;

   always_comb begin
      state_in   = state_ff;
      ptr_in     = ptr_ff;
      chk_vld_in = 1'b0;
      chk_ptr_in = ptr_ff[ADDR_W-1:0];
      found_in   = found_ff;
      prev_in    = prev_ff;
      head_in    = head_ff;
      cur_in     = cur_ff;
      n_in       = n_ff;
      op_in      = op_ff;
      res_in     = res_ff;
      op_pop     = 1'b0;
      wr_en      = 1'b0;
      wr_addr    = ptr_ff[ADDR_W-1:0];
      wr_data    = ENT_EMPTY;
      rd_addr    = ptr_ff[ADDR_W-1:0];

      case (state_ff)
         S_CLEAR: begin
            // after reset, clear the table one entry at a time; root directory gets the end mark
            wr_en   = 1'b1;
            wr_data = (ptr_ff == CNT_W'(FIRST_DATA_CLUSTER)) ? ENT_END : ENT_EMPTY;
            ptr_in  = ptr_ff + CNT_W'(1);
            if (ptr_ff == CNT_W'(TABLE_SIZE - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (op_valid) begin
               op_pop   = 1'b1;
               op_in    = op_data;
               res_in   = '0;
               ptr_in   = CNT_W'(FIRST_DATA_CLUSTER);
               found_in = '0;
               n_in     = '0;
               cur_in   = ADDR_W'(op_data.start);
               case (op_data.cmd)
                  CMD_ALLOC: state_in = S_A_CNT;
                  CMD_FREE, CMD_WALK: begin
                     if (op_data.start_bad) begin
                        res_in.status = ST_BAD;
                        state_in      = S_DONE;
                     end else begin
                        state_in = S_W_RD;
                     end
                  end
                  default: state_in = S_DONE;
               endcase
            end
         end
         S_A_CNT: begin
            // reads stream one address ahead of the check
            chk_vld_in = issue;
            if (issue) begin
               ptr_in = ptr_ff + CNT_W'(1);
            end
            if (hit) begin
               found_in = found_nx;
            end
            if (hit && found_nx == op_ff.want) begin
               ptr_in     = CNT_W'(FIRST_DATA_CLUSTER);
               chk_vld_in = 1'b0;
               found_in   = '0;
               state_in   = S_A_LINK;
            end else if (last_chk) begin
               res_in.status = ST_FULL;
               state_in      = S_DONE;
            end
         end
         S_A_LINK: begin
            chk_vld_in = issue;
            if (issue) begin
               ptr_in = ptr_ff + CNT_W'(1);
            end
            if (hit) begin
               found_in = found_nx;
               prev_in  = chk_ptr_ff;
               if (found_ff == '0) begin
                  head_in = chk_ptr_ff;
               end else begin
                  wr_en   = 1'b1;
                  wr_addr = prev_ff;
                  wr_data = {1'b0, chk_ptr_ff};
               end
               if (found_nx == op_ff.want) begin
                  chk_vld_in = 1'b0;
                  state_in   = S_A_END;
               end
            end
         end
         S_A_END: begin
            wr_en               = 1'b1;
            wr_addr             = prev_ff;
            wr_data             = ENT_END;
            res_in.head_cluster = FIELD_W'(head_ff);
            res_in.chain_length = op_ff.want;
            res_in.status       = ST_OK;
            state_in            = S_DONE;
         end
         S_W_RD: begin
            rd_addr  = cur_ff;
            state_in = S_W_CHK;
         end
         S_W_CHK: begin
            if (rd_data == ENT_EMPTY) begin
               res_in.status = ST_BAD;
               state_in      = S_DONE;
            end else if (n_nx > CNT_W'(DATA_CLUSTERS)) begin
               res_in.status = ST_LONG;
               state_in      = S_DONE;
            end else if (rd_data == ENT_END) begin
               n_in = n_nx;
               if (op_ff.cmd == CMD_FREE) begin
                  cur_in   = ADDR_W'(op_ff.start);
                  state_in = S_F_RD;
               end else begin
                  res_in.chain_length = FIELD_W'(n_nx);
                  state_in            = S_DONE;
               end
            end else if (rd_data[ADDR_W] ||
                         link < ADDR_W'(FIRST_DATA_CLUSTER)) begin
               res_in.status = ST_BAD;
               state_in      = S_DONE;
            end else begin
               n_in     = n_nx;
               cur_in   = link;
               state_in = S_W_RD;
            end
         end
         S_F_RD: begin
            rd_addr  = cur_ff;
            state_in = S_F_CLR;
         end
         S_F_CLR: begin
            // chain already checked, so it ends at its end mark
            wr_en   = 1'b1;
            wr_addr = cur_ff;
            wr_data = ENT_EMPTY;
            if (rd_data[ADDR_W] || link < ADDR_W'(FIRST_DATA_CLUSTER)) begin
               res_in.chain_length = FIELD_W'(n_ff);
               state_in            = S_DONE;
            end else begin
               cur_in   = link;
               state_in = S_F_RD;
            end
         end
         S_DONE: begin
            if (!res_full) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_CLEAR;
         ptr_ff     <= '0;
         chk_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         ptr_ff     <= ptr_in;
         chk_vld_ff <= chk_vld_in;
      end
      chk_ptr_ff <= chk_ptr_in;
      found_ff   <= found_in;
      prev_ff    <= prev_in;
      head_ff    <= head_in;
      cur_ff     <= cur_in;
      n_ff       <= n_in;
      op_ff      <= op_in;
      res_ff     <= res_in;
   end

endmodule

// ----- hw/rtl/fcc_checker.sv -----
`include "assert_macros.svh"

module fcc_checker
   import fcc_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_full,
   input logic    rsp_empty,
   input logic    rsp_pop,
   input rsp_type rsp_data
);

   logic rsp_err, rsp_clean, head_set, head_ok;

   assign rsp_err   = !rsp_empty && rsp_data.status != ST_OK;
   assign rsp_clean = rsp_data.head_cluster == '0 && rsp_data.chain_length == '0;
   assign head_set  = !rsp_empty && rsp_data.head_cluster != '0;
   assign head_ok   = rsp_data.head_cluster >= FIELD_W'(FIRST_DATA_CLUSTER) &&
                      rsp_data.status == ST_OK;

   // errors carry no head and no length
   `ASSERT_SAME(a_err_zero, clock, reset, rsp_err, rsp_clean)
   // a fresh allocation heads at a data cluster
   `ASSERT_SAME(a_head_data, clock, reset, head_set, head_ok)
   // nothing to deliver and room for requests right after reset
   `ASSERT_NEXT(a_empty_after_reset, clock, 1'b0, reset, rsp_empty && !req_full)
   `ASSERT_NEXT(a_rsp_hold, clock, reset, !rsp_empty && !rsp_pop, !rsp_empty && $stable(rsp_data))

endmodule

bind fat_cluster_chain_engine_core fcc_checker u_fcc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_full  (req_full),
   .rsp_empty (rsp_empty),
   .rsp_pop   (rsp_pop),
   .rsp_data  (rsp_data)
);
